@@ hw/rtl/pgal_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pgal_pkg
// Shared codes and types of the page range first-fit allocator.
// ----------------------------------------------------------------------------
package pgal_pkg;

   // request opcodes
   localparam logic [1:0] OP_INIT  = 2'd0;
   localparam logic [1:0] OP_ALLOC = 2'd1;
   localparam logic [1:0] OP_FREE  = 2'd2;

   // response status codes
   localparam logic [1:0] ST_OK   = 2'd0;
   localparam logic [1:0] ST_FAIL = 2'd1;
   localparam logic [1:0] ST_FULL = 2'd2;

   // configuration register indexes
   localparam int unsigned CSR_INDEX_W = 1;
   localparam logic [CSR_INDEX_W-1:0] CSR_FREE_FIRST = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_FREE_END   = 1'b1;

   // compare results of one extent against the current request
   typedef struct packed {
      logic size_gt;      // extent larger than the requested count
      logic size_eq;      // extent exactly the requested count
      logic touch_front;  // freed run ends where the extent starts
      logic touch_back;   // freed run starts where the extent ends
      logic start_after;  // extent starts above the freed run
   } pgal_flags_type;

endpackage

@@ hw/rtl/pgal_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pgal_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module pgal_ram #(
   parameter int unsigned WIDTH = 72,
   parameter int unsigned DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // write port
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

@@ hw/rtl/pgal_eval.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pgal_eval
// Shared compare unit: checks one extent entry against the current request.
// ----------------------------------------------------------------------------
module pgal_eval #(
   parameter int unsigned PAGE_NUMBER_BITS = 36
) (
   input  logic [PAGE_NUMBER_BITS-1:0] ent_start,
   input  logic [PAGE_NUMBER_BITS-1:0] ent_end,
   input  logic [PAGE_NUMBER_BITS-1:0] req_first,
   input  logic [PAGE_NUMBER_BITS-1:0] req_count,
   input  logic [PAGE_NUMBER_BITS-1:0] req_run_end,
   output pgal_pkg::pgal_flags_type    flags,
   output logic [PAGE_NUMBER_BITS-1:0] cut_start
);
   import pgal_pkg::*;

   logic [PAGE_NUMBER_BITS-1:0] size;

   // extent size, modulo the page number width
   assign size = ent_end - ent_start;

   // fit and touch compares
   always_comb begin
      flags.size_gt     = size > req_count;
      flags.size_eq     = size == req_count;
      flags.touch_front = req_run_end == ent_start;
      flags.touch_back  = req_first == ent_end;
      flags.start_after = ent_start > req_first;
   end

   // new start of an extent cut from its front
   assign cut_start = ent_start + req_count;

endmodule

@@ hw/rtl/page_range_first_fit_allocator.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// page_range_first_fit_allocator
// First-fit allocator over a sorted table of free page extents.
// ----------------------------------------------------------------------------
// One request is handled at a time; req_ready is high only while the block
// is idle, and the response sits in an output register so a new request can
// be taken while it waits. An allocate or free walks the extent table
// through the single read port of the extent RAM, one entry a cycle, and
// stops at the first entry that it cuts or extends. An exact-fit allocate
// then moves every entry behind the removed one down a slot; a free that
// inserts moves the entries from the insert position up a slot and then
// writes the new extent into the opened slot. Register writes to csr_*
// take effect at the next init. Table entries are not cleared at reset;
// only entries below the fill count are ever read.
// ----------------------------------------------------------------------------
module page_range_first_fit_allocator #(
   parameter int unsigned EXTENT_SLOTS     = 16,
   parameter int unsigned PAGE_NUMBER_BITS = 36
) (
   input  logic                             clock,
   input  logic                             reset,
   // configuration
   input  logic                             csr_we,
   input  logic [pgal_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [PAGE_NUMBER_BITS-1:0]      csr_wdata,
   // request
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [1:0]                       req_opcode,
   input  logic [PAGE_NUMBER_BITS-1:0]      req_first_page,
   input  logic [PAGE_NUMBER_BITS-1:0]      req_page_count,
   // response
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [PAGE_NUMBER_BITS-1:0]      rsp_granted_page,
   output logic [1:0]                       rsp_status,
   output logic [PAGE_NUMBER_BITS-1:0]      rsp_available_pages
);
   import pgal_pkg::*;

   localparam int unsigned PNB   = PAGE_NUMBER_BITS;
   localparam int unsigned IDX_W = $clog2(EXTENT_SLOTS);
   localparam int unsigned CNT_W = $clog2(EXTENT_SLOTS + 1);
   localparam logic [CNT_W-1:0] SLOTS_CNT = CNT_W'(EXTENT_SLOTS);

   // sequencer states
   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_CHECK  = 3'd1;
   localparam logic [2:0] S_WALK   = 3'd2;
   localparam logic [2:0] S_SHIFT  = 3'd3;
   localparam logic [2:0] S_PUT    = 3'd4;
   localparam logic [2:0] S_FINISH = 3'd5;

   logic [2:0]       state_ff, state_in;
   logic [1:0]       op_ff, op_in;
   logic [PNB-1:0]   first_ff, first_in;
   logic [PNB-1:0]   cnt_ff, cnt_in;
   logic [PNB:0]     run_end_ff, run_end_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [PNB-1:0]   free_pages_ff, free_pages_in;
   logic [PNB-1:0]   cfg_first_ff, cfg_first_in;
   logic [PNB-1:0]   cfg_end_ff, cfg_end_in;
   logic [CNT_W-1:0] rd_idx_ff, rd_idx_in;
   logic             ev_vld_ff, ev_vld_in;
   logic [IDX_W-1:0] ev_idx_ff, ev_idx_in;
   logic             pos_found_ff, pos_found_in;
   logic [IDX_W-1:0] pos_ff, pos_in;
   logic             shift_up_ff, shift_up_in;
   logic [IDX_W-1:0] sp_ff, sp_in;
   logic [CNT_W-1:0] left_ff, left_in;
   logic             pend_ff, pend_in;
   logic [IDX_W-1:0] pend_addr_ff, pend_addr_in;
   logic [1:0]       res_status_ff, res_status_in;
   logic [PNB-1:0]   res_granted_ff, res_granted_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [PNB-1:0]   rsp_granted_ff, rsp_granted_in;
   logic [1:0]       rsp_status_ff, rsp_status_in;
   logic [PNB-1:0]   rsp_avail_ff, rsp_avail_in;

   // extent RAM ports
   logic             mem_we;
   logic [IDX_W-1:0] mem_waddr;
   logic [IDX_W-1:0] mem_raddr;
   logic [2*PNB-1:0] mem_wdata;
   logic [2*PNB-1:0] mem_rdata;
   logic [PNB-1:0]   ent_start;
   logic [PNB-1:0]   ent_end;

   // compare unit results
   pgal_flags_type   flags;
   logic [PNB-1:0]   cut_start;

   // helpers
   logic [PNB:0]     free_sum;
   logic [PNB-1:0]   free_added;
   logic             issue;
   logic [IDX_W-1:0] pos_eff;

   assign ent_start = mem_rdata[2*PNB-1:PNB];
   assign ent_end   = mem_rdata[PNB-1:0];

   pgal_ram #(
      .WIDTH (2 * PNB),
      .DEPTH (EXTENT_SLOTS)
   ) u_extents (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (mem_wdata),
      .raddr (mem_raddr),
      .rdata (mem_rdata)
   );

   pgal_eval #(
      .PAGE_NUMBER_BITS (PNB)
   ) u_eval (
      .ent_start   (ent_start),
      .ent_end     (ent_end),
      .req_first   (first_ff),
      .req_count   (cnt_ff),
      .req_run_end (run_end_ff[PNB-1:0]),
      .flags       (flags),
      .cut_start   (cut_start)
   );

   // saturating add of a freed run to the page count
   assign free_sum   = {1'b0, free_pages_ff} + {1'b0, cnt_ff};
   assign free_added = free_sum[PNB] ? {PNB{1'b1}} : free_sum[PNB-1:0];

   // insert position: first entry starting above the run, else the end
   assign pos_eff = pos_found_ff ? pos_ff : count_ff[IDX_W-1:0];

   // sequencer
   always_comb begin
      state_in       = state_ff;
      op_in          = op_ff;
      first_in       = first_ff;
      cnt_in         = cnt_ff;
      run_end_in     = run_end_ff;
      count_in       = count_ff;
      free_pages_in  = free_pages_ff;
      rd_idx_in      = rd_idx_ff;
      ev_vld_in      = 1'b0;
      ev_idx_in      = ev_idx_ff;
      pos_found_in   = pos_found_ff;
      pos_in         = pos_ff;
      shift_up_in    = shift_up_ff;
      sp_in          = sp_ff;
      left_in        = left_ff;
      pend_in        = 1'b0;
      pend_addr_in   = pend_addr_ff;
      res_status_in  = res_status_ff;
      res_granted_in = res_granted_ff;
      rsp_valid_in   = rsp_valid_ff & ~rsp_ready;
      rsp_granted_in = rsp_granted_ff;
      rsp_status_in  = rsp_status_ff;
      rsp_avail_in   = rsp_avail_ff;
      mem_we         = 1'b0;
      mem_waddr      = '0;
      mem_wdata      = mem_rdata;
      mem_raddr      = '0;
      issue          = 1'b0;
      req_ready      = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               op_in      = req_opcode;
               first_in   = req_first_page;
               cnt_in     = req_page_count;
               run_end_in = {1'b0, req_first_page} + {1'b0, req_page_count};
               state_in   = S_CHECK;
            end
         end

         // argument checks and init
         S_CHECK: begin
            res_granted_in = '0;
            res_status_in  = ST_FAIL;
            rd_idx_in      = '0;
            pos_found_in   = 1'b0;
            state_in       = S_FINISH;
            case (op_ff)
               OP_INIT: begin
                  res_status_in = ST_OK;
                  if (cfg_end_ff > cfg_first_ff) begin
                     mem_we        = 1'b1;
                     mem_waddr     = '0;
                     mem_wdata     = {cfg_first_ff, cfg_end_ff};
                     count_in      = CNT_W'(1);
                     free_pages_in = cfg_end_ff - cfg_first_ff;
                  end else begin
                     count_in      = '0;
                     free_pages_in = '0;
                  end
               end
               OP_ALLOC: begin
                  if (cnt_ff != '0 && cnt_ff <= free_pages_ff) begin
                     state_in = S_WALK;
                  end
               end
               OP_FREE: begin
                  if (first_ff != '0 && cnt_ff != '0 && !run_end_ff[PNB]) begin
                     state_in = S_WALK;
                  end
               end
               default: begin
                  res_status_in = ST_FAIL;
               end
            endcase
         end

         // walk the table, one read issued and one entry checked per cycle
         S_WALK: begin
            issue     = rd_idx_ff < count_ff;
            mem_raddr = rd_idx_ff[IDX_W-1:0];
            ev_vld_in = issue;
            ev_idx_in = rd_idx_ff[IDX_W-1:0];
            if (issue) begin
               rd_idx_in = rd_idx_ff + CNT_W'(1);
            end
            if (ev_vld_ff) begin
               if (op_ff == OP_ALLOC) begin
                  if (flags.size_gt) begin
                     mem_we         = 1'b1;
                     mem_waddr      = ev_idx_ff;
                     mem_wdata      = {cut_start, ent_end};
                     res_granted_in = ent_start;
                     res_status_in  = ST_OK;
                     free_pages_in  = free_pages_ff - cnt_ff;
                     state_in       = S_FINISH;
                  end else if (flags.size_eq) begin
                     // exact fit: close the gap behind this entry
                     res_granted_in = ent_start;
                     res_status_in  = ST_OK;
                     free_pages_in  = free_pages_ff - cnt_ff;
                     count_in       = count_ff - CNT_W'(1);
                     shift_up_in    = 1'b0;
                     sp_in          = ev_idx_ff + IDX_W'(1);
                     left_in        = count_ff - CNT_W'(ev_idx_ff) - CNT_W'(1);
                     state_in       = S_SHIFT;
                  end
               end else begin
                  if (flags.touch_front) begin
                     mem_we        = 1'b1;
                     mem_waddr     = ev_idx_ff;
                     mem_wdata     = {first_ff, ent_end};
                     res_status_in = ST_OK;
                     free_pages_in = free_added;
                     state_in      = S_FINISH;
                  end else if (flags.touch_back) begin
                     mem_we        = 1'b1;
                     mem_waddr     = ev_idx_ff;
                     mem_wdata     = {ent_start, run_end_ff[PNB-1:0]};
                     res_status_in = ST_OK;
                     free_pages_in = free_added;
                     state_in      = S_FINISH;
                  end else if (flags.start_after && !pos_found_ff) begin
                     pos_found_in = 1'b1;
                     pos_in       = ev_idx_ff;
                  end
               end
            end else if (!issue) begin
               // walk ended without a hit
               if (op_ff == OP_ALLOC) begin
                  res_status_in = ST_FAIL;
                  state_in      = S_FINISH;
               end else if (count_ff >= SLOTS_CNT) begin
                  res_status_in = ST_FULL;
                  state_in      = S_FINISH;
               end else begin
                  pos_in      = pos_eff;
                  shift_up_in = 1'b1;
                  sp_in       = count_ff[IDX_W-1:0] - IDX_W'(1);
                  left_in     = count_ff - CNT_W'(pos_eff);
                  state_in    = S_SHIFT;
               end
            end
         end

         // move entries one slot up or down, each read and then written in the next cycle
         S_SHIFT: begin
            issue     = left_ff != '0;
            mem_raddr = sp_ff;
            if (issue) begin
               left_in      = left_ff - CNT_W'(1);
               sp_in        = shift_up_ff ? sp_ff - IDX_W'(1) : sp_ff + IDX_W'(1);
               pend_in      = 1'b1;
               pend_addr_in = shift_up_ff ? sp_ff + IDX_W'(1) : sp_ff - IDX_W'(1);
            end
            if (pend_ff) begin
               mem_we    = 1'b1;
               mem_waddr = pend_addr_ff;
               mem_wdata = mem_rdata;
            end
            if (!issue && !pend_ff) begin
               state_in = shift_up_ff ? S_PUT : S_FINISH;
            end
         end

         // write the inserted extent into the opened slot
         S_PUT: begin
            mem_we        = 1'b1;
            mem_waddr     = pos_ff;
            mem_wdata     = {first_ff, run_end_ff[PNB-1:0]};
            count_in      = count_ff + CNT_W'(1);
            free_pages_in = free_added;
            res_status_in = ST_OK;
            state_in      = S_FINISH;
         end

         // hand the result to the output register once it is free
         S_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in   = 1'b1;
               rsp_granted_in = res_granted_ff;
               rsp_status_in  = res_status_ff;
               rsp_avail_in   = free_pages_ff;
               state_in       = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // configuration registers
   always_comb begin
      cfg_first_in = cfg_first_ff;
      cfg_end_in   = cfg_end_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_FREE_FIRST: cfg_first_in = csr_wdata;
            CSR_FREE_END:   cfg_end_in   = csr_wdata;
            default: begin
               cfg_first_in = cfg_first_ff;
            end
         endcase
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         count_ff      <= '0;
         free_pages_ff <= '0;
         cfg_first_ff  <= '0;
         cfg_end_ff    <= '0;
         ev_vld_ff     <= 1'b0;
         pend_ff       <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         free_pages_ff <= free_pages_in;
         cfg_first_ff  <= cfg_first_in;
         cfg_end_ff    <= cfg_end_in;
         ev_vld_ff     <= ev_vld_in;
         pend_ff       <= pend_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload and working registers
   always_ff @(posedge clock) begin
      op_ff          <= op_in;
      first_ff       <= first_in;
      cnt_ff         <= cnt_in;
      run_end_ff     <= run_end_in;
      rd_idx_ff      <= rd_idx_in;
      ev_idx_ff      <= ev_idx_in;
      pos_found_ff   <= pos_found_in;
      pos_ff         <= pos_in;
      shift_up_ff    <= shift_up_in;
      sp_ff          <= sp_in;
      left_ff        <= left_in;
      pend_addr_ff   <= pend_addr_in;
      res_status_ff  <= res_status_in;
      res_granted_ff <= res_granted_in;
      rsp_granted_ff <= rsp_granted_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_avail_ff   <= rsp_avail_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_granted_page    = rsp_granted_ff;
   assign rsp_status          = rsp_status_ff;
   assign rsp_available_pages = rsp_avail_ff;

endmodule

@@ sim/page_range_first_fit_allocator_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// page_range_first_fit_allocator_test
// Self-checking bench for the first-fit page extent allocator.
// ----------------------------------------------------------------------------
// A model of the extent table, the free page count and the two config
// registers runs next to the block. Each request word accepted at the input
// produces one expected response word, which is compared field by field
// with the response words that leave the block. Directed tests cover the
// full page span, grants of page zero, invalid requests, count saturation,
// a full table and one long response stall; random traffic then allocates
// runs and hands them back in random order, mixed with malformed requests,
// under three idle patterns.
// ----------------------------------------------------------------------------
module page_range_first_fit_allocator_test;
   import pgal_pkg::*;

   localparam int unsigned SLOTS     = 16;
   localparam int unsigned PAGE_W    = 36;
   localparam int unsigned SETTLE_CYCLES = 2 * SLOTS + 10;
   localparam int unsigned CYCLE_LIMIT   = 500000;
   localparam int unsigned RECONFIG_EVERY = 120;

   // opcode the block does not define
   localparam logic [1:0] OP_UNUSED = 2'd3;

   typedef logic [PAGE_W-1:0] page_type;
   localparam page_type PAGE_MAX = {PAGE_W{1'b1}};

   typedef struct {
      page_type   granted;
      logic [1:0] status;
      page_type   avail;
   } result_word_type;

   typedef struct {
      page_type first;
      page_type count;
   } run_type;

   logic                   clock;
   logic                   reset;
   logic                   csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   page_type               csr_wdata;
   logic                   req_valid;
   logic                   req_ready;
   logic [1:0]             req_opcode;
   page_type               req_first_page;
   page_type               req_page_count;
   logic                   rsp_valid;
   logic                   rsp_ready;
   page_type               rsp_granted_page;
   logic [1:0]             rsp_status;
   page_type               rsp_available_pages;

   // model state
   page_type ext_start [SLOTS];
   page_type ext_end   [SLOTS];
   int       ext_used;
   page_type pages_avail;
   page_type cfg_first_page;
   page_type cfg_end_page;

   result_word_type expected_words [$];
   run_type         granted_runs [$];

   int error_count;
   int cycle_count;
   int send_idle_pct;
   int recv_idle_pct;
   int hold_len;

   page_range_first_fit_allocator #(
      .EXTENT_SLOTS     (SLOTS),
      .PAGE_NUMBER_BITS (PAGE_W)
   ) dut (
      .clock               (clock),
      .reset               (reset),
      .csr_we              (csr_we),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_opcode          (req_opcode),
      .req_first_page      (req_first_page),
      .req_page_count      (req_page_count),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_granted_page    (rsp_granted_page),
      .rsp_status          (rsp_status),
      .rsp_available_pages (rsp_available_pages)
   );

   // clock
   initial clock = 1'b0;
   always #10 clock = ~clock;

   // run limit
   always @(posedge clock) begin
      cycle_count = cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("page_range_first_fit_allocator regression: fail");
         $finish;
      end
   end

   // add freed pages, saturating at the largest count
   function automatic void credit_pages(page_type cnt);
      logic [PAGE_W:0] sum;
      sum = {1'b0, pages_avail} + {1'b0, cnt};
      pages_avail = sum[PAGE_W] ? PAGE_MAX : sum[PAGE_W-1:0];
   endfunction

   // first-fit allocate: cut the front of a larger extent or drop an exact one
   function automatic void take_first_fit(page_type cnt, ref result_word_type r);
      page_type size;
      bit       done;
      done = 1'b0;
      if (cnt != '0 && cnt <= pages_avail) begin
         for (int i = 0; i < ext_used && !done; i++) begin
            size = ext_end[i] - ext_start[i];
            if (size > cnt) begin
               r.granted = ext_start[i];
               ext_start[i] = ext_start[i] + cnt;
               pages_avail = pages_avail - cnt;
               r.status = ST_OK;
               done = 1'b1;
            end else if (size == cnt) begin
               r.granted = ext_start[i];
               for (int k = i; k + 1 < ext_used; k++) begin
                  ext_start[k] = ext_start[k + 1];
                  ext_end[k]   = ext_end[k + 1];
               end
               ext_used = ext_used - 1;
               pages_avail = pages_avail - cnt;
               r.status = ST_OK;
               done = 1'b1;
            end
         end
      end
   endfunction

   // free: extend the first touching extent, else insert in start order
   function automatic void give_back(page_type first, page_type cnt,
                                     ref result_word_type r);
      logic [PAGE_W:0] run_end;
      int              pos;
      bit              done;
      done = 1'b0;
      run_end = {1'b0, first} + {1'b0, cnt};
      if (first == '0 || cnt == '0 || run_end[PAGE_W])
         return;
      for (int i = 0; i < ext_used && !done; i++) begin
         if (run_end[PAGE_W-1:0] == ext_start[i]) begin
            ext_start[i] = first;
            done = 1'b1;
         end else if (first == ext_end[i]) begin
            ext_end[i] = run_end[PAGE_W-1:0];
            done = 1'b1;
         end
      end
      if (!done) begin
         if (ext_used >= SLOTS) begin
            r.status = ST_FULL;
            return;
         end
         pos = ext_used;
         for (int i = ext_used - 1; i >= 0; i--)
            if (ext_start[i] > first) pos = i;
         for (int k = ext_used; k > pos; k--) begin
            ext_start[k] = ext_start[k - 1];
            ext_end[k]   = ext_end[k - 1];
         end
         ext_start[pos] = first;
         ext_end[pos]   = run_end[PAGE_W-1:0];
         ext_used = ext_used + 1;
      end
      credit_pages(cnt);
      r.status = ST_OK;
   endfunction

   // expected response word for one request word, updating the model
   function automatic result_word_type predict_extent_op(logic [1:0] op, page_type first,
                                                         page_type cnt);
      result_word_type r;
      r.granted = '0;
      r.status  = ST_FAIL;
      case (op)
         OP_INIT: begin
            if (cfg_end_page > cfg_first_page) begin
               ext_start[0] = cfg_first_page;
               ext_end[0]   = cfg_end_page;
               ext_used     = 1;
               pages_avail  = cfg_end_page - cfg_first_page;
            end else begin
               ext_used    = 0;
               pages_avail = '0;
            end
            r.status = ST_OK;
         end
         OP_ALLOC: take_first_fit(cnt, r);
         OP_FREE:  give_back(first, cnt, r);
         default:  r.status = ST_FAIL;
      endcase
      r.avail = pages_avail;
      return r;
   endfunction

   function automatic page_type rand_page();
      return page_type'({$urandom(), $urandom()});
   endfunction

   // receiver: random idling, or a counted hold-off when one is asked for
   always @(negedge clock) begin
      if (hold_len > 0) begin
         rsp_ready = 1'b0;
         hold_len  = hold_len - 1;
      end else begin
         rsp_ready = ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   function automatic void check_field(string name, page_type exp_v, page_type act_v);
      if (exp_v !== act_v) begin
         $display("%0t: %s mismatch, expected %h actual %h", $time, name, exp_v, act_v);
         error_count = error_count + 1;
      end
   endfunction

   // response checker
   always @(posedge clock) begin
      result_word_type exp_w;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_words.size() == 0) begin
            $display("%0t: unexpected response word, expected none actual %h/%h/%h",
                     $time, rsp_granted_page, rsp_status, rsp_available_pages);
            error_count = error_count + 1;
         end else begin
            exp_w = expected_words.pop_front();
            check_field("granted_page", exp_w.granted, rsp_granted_page);
            check_field("status", page_type'(exp_w.status), page_type'(rsp_status));
            check_field("available_pages", exp_w.avail, rsp_available_pages);
         end
      end
   end

   // send one request word; returns at the accepting rising edge
   task automatic send_word(input logic [1:0] op, input page_type first,
                            input page_type cnt, output result_word_type res);
      @(negedge clock);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid      = 1'b1;
      req_opcode     = op;
      req_first_page = first;
      req_page_count = cnt;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      res = predict_extent_op(op, first, cnt);
      expected_words.push_back(res);
   endtask

   task automatic send(input logic [1:0] op, input page_type first, input page_type cnt);
      result_word_type res;
      send_word(op, first, cnt, res);
   endtask

   // stop offering and wait for every outstanding response word
   task automatic drain(input bit settle);
      @(negedge clock);
      req_valid = 1'b0;
      while (expected_words.size() != 0) @(posedge clock);
      if (settle) repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // config write, only while the block is idle
   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx, input page_type data);
      @(negedge clock);
      csr_we    = 1'b1;
      csr_index = idx;
      csr_wdata = data;
      @(negedge clock);
      csr_we = 1'b0;
      if (idx == CSR_FREE_FIRST) cfg_first_page = data;
      else cfg_end_page = data;
   endtask

   // whole page space, page zero grants, invalid words, saturation
   task automatic test_full_span();
      write_reg(CSR_FREE_FIRST, '0);
      write_reg(CSR_FREE_END, PAGE_MAX);
      send(OP_INIT, rand_page(), rand_page());
      send(OP_ALLOC, rand_page(), '0);
      send(OP_ALLOC, '0, PAGE_MAX);
      send(OP_FREE, '0, 5);
      send(OP_FREE, PAGE_MAX, 1);
      send(OP_FREE, 1, PAGE_MAX - 1);
      send(OP_FREE, 100, 7);
      send(OP_UNUSED, rand_page(), rand_page());
      send(OP_ALLOC, PAGE_MAX, PAGE_MAX);
      send(OP_ALLOC, '0, PAGE_MAX - 1);
      drain(1'b0);
   endtask

   // empty init ranges, late register effect, full table, extends, no fit
   task automatic test_table_limits();
      write_reg(CSR_FREE_FIRST, PAGE_MAX);
      write_reg(CSR_FREE_END, '0);
      // registers only count at the next init
      send(OP_ALLOC, '0, 1);
      send(OP_INIT, '0, '0);
      send(OP_ALLOC, '0, 1);
      drain(1'b0);
      write_reg(CSR_FREE_FIRST, page_type'(36'h0_0010_0000));
      write_reg(CSR_FREE_END, page_type'(36'h0_0010_0000));
      send(OP_INIT, '0, '0);
      // descending single pages insert at the front until the table is full
      for (int k = SLOTS + 1; k >= 1; k--)
         send(OP_FREE, page_type'(2 * k), 1);
      send(OP_FREE, 3, 1);
      send(OP_FREE, page_type'(2 * SLOTS + 3), 1);
      send(OP_ALLOC, '0, 3);
      send(OP_ALLOC, '0, 1);
      send(OP_ALLOC, '0, 1);
      drain(1'b0);
   endtask

   // long response stall while requests keep coming
   task automatic test_backpressure();
      write_reg(CSR_FREE_FIRST, page_type'(1024));
      write_reg(CSR_FREE_END, page_type'(1224));
      send(OP_INIT, '0, '0);
      hold_len = 400;
      for (int k = 0; k < 12; k++)
         send(OP_ALLOC, rand_page(), page_type'($urandom_range(1, 8)));
      drain(1'b0);
   endtask

   // random init range: mostly small and aligned, sometimes wide or empty
   task automatic new_config();
      int       sel;
      page_type first;
      sel = $urandom_range(0, 9);
      if (sel == 0) begin
         write_reg(CSR_FREE_FIRST, rand_page());
         write_reg(CSR_FREE_END, rand_page());
      end else if (sel == 1) begin
         first = rand_page();
         write_reg(CSR_FREE_FIRST, first);
         write_reg(CSR_FREE_END, first - page_type'($urandom_range(0, 3)));
      end else begin
         first = page_type'($urandom_range(0, 1 << 26)) << 9;
         write_reg(CSR_FREE_FIRST, first);
         write_reg(CSR_FREE_END, first + page_type'($urandom_range(32, 3000)));
      end
   endtask

   // allocate runs and return them in random order, mixed with junk words
   task automatic test_random_traffic(input int count);
      result_word_type res;
      run_type         r;
      int              pick;
      int              idx;
      page_type        cnt;
      for (int n = 0; n < count; n++) begin
         if (n % RECONFIG_EVERY == 0) begin
            drain(1'b0);
            new_config();
            send(OP_INIT, rand_page(), rand_page());
            granted_runs.delete();
         end
         pick = $urandom_range(0, 99);
         if (pick >= 85) begin
            case ($urandom_range(0, 6))
               0: send(OP_UNUSED, rand_page(), rand_page());
               1: send(OP_FREE, rand_page(), rand_page());
               2: send(OP_FREE, '0, rand_page());
               3: send(OP_FREE, rand_page(), '0);
               4: send(OP_ALLOC, rand_page(), '0);
               5: send(OP_ALLOC, rand_page(), rand_page());
               default: begin
                  send(OP_INIT, rand_page(), rand_page());
                  granted_runs.delete();
               end
            endcase
         end else if (pick >= 45 && granted_runs.size() != 0) begin
            idx = $urandom_range(0, granted_runs.size() - 1);
            r = granted_runs[idx];
            granted_runs.delete(idx);
            // sometimes only the head of the run comes back
            cnt = ($urandom_range(0, 3) == 0)
                  ? page_type'($urandom_range(1, 32'(r.count)))
                  : r.count;
            send(OP_FREE, r.first, cnt);
         end else begin
            cnt = ($urandom_range(0, 9) == 0) ? page_type'($urandom_range(1, 400))
                                              : page_type'($urandom_range(1, 16));
            send_word(OP_ALLOC, rand_page(), cnt, res);
            if (res.status == ST_OK) begin
               r.first = res.granted;
               r.count = cnt;
               granted_runs.push_back(r);
            end
         end
      end
      drain(1'b0);
   endtask

   initial begin
      error_count    = 0;
      cycle_count    = 0;
      hold_len       = 0;
      send_idle_pct  = 36;
      recv_idle_pct  = 73;
      ext_used       = 0;
      pages_avail    = '0;
      cfg_first_page = '0;
      cfg_end_page   = '0;
      reset          = 1'b1;
      csr_we         = 1'b0;
      csr_index      = '0;
      csr_wdata      = '0;
      req_valid      = 1'b0;
      req_opcode     = OP_INIT;
      req_first_page = '0;
      req_page_count = '0;
      rsp_ready      = 1'b0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_full_span();
      test_table_limits();
      test_backpressure();
      test_random_traffic(480);

      send_idle_pct = 73;
      recv_idle_pct = 36;
      test_random_traffic(480);

      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_random_traffic(480);

      drain(1'b1);
      if (error_count == 0)
         $display("page_range_first_fit_allocator regression: pass");
      else
         $display("page_range_first_fit_allocator regression: fail");
      $finish;
   end

endmodule
